// ===== rtl/core/bvm_pkg.sv =====
// Shared types and constants of the byte VM instruction executor.
package bvm_pkg;

    localparam int NUM_REGS = 16;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int WORD_W   = 8;
    localparam int MAX_PROG = 256;
    localparam int SIZE_W   = 9;
    localparam int MOD_STEPS = SIZE_W;

    localparam logic [7:0] OP_INC  = 8'd1;
    localparam logic [7:0] OP_DEC  = 8'd2;
    localparam logic [7:0] OP_MOV  = 8'd3;
    localparam logic [7:0] OP_LDI  = 8'd4;
    localparam logic [7:0] OP_SHL  = 8'd5;
    localparam logic [7:0] OP_SHR  = 8'd6;
    localparam logic [7:0] OP_JMP  = 8'd7;
    localparam logic [7:0] OP_JZ   = 8'd8;
    localparam logic [7:0] OP_JNZ  = 8'd9;
    localparam logic [7:0] OP_JEOF = 8'd10;
    localparam logic [7:0] OP_HALT = 8'd11;
    localparam logic [7:0] OP_ADD  = 8'd12;
    localparam logic [7:0] OP_SUB  = 8'd13;
    localparam logic [7:0] OP_XOR  = 8'd14;
    localparam logic [7:0] OP_OR   = 8'd15;
    localparam logic [7:0] OP_IN   = 8'd16;
    localparam logic [7:0] OP_OUT  = 8'd17;

    localparam logic [7:0] PC_STEP  = 8'd2;
    localparam logic [7:0] EOF_BYTE = 8'hFF;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] operand;
        logic [7:0] in_byte;
        logic       in_eof;
    } in_item_t;

    typedef struct packed {
        logic [7:0] next_pc;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       took_input;
        logic       zero;
        logic       halted;
    } res_item_t;

endpackage

// ===== rtl/core/bvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/byte_vm_instruction_executor.sv =====
// Top level of the byte VM instruction executor: sequencer, ALU and register file.
//
// Usage: one item on the input channel (in_valid/in_ready, payload in_item) carries
// one two-byte instruction plus the next input-stream byte and its end flag. For
// each item exactly one result item leaves on the result channel (res_valid/
// res_ready, payload res_item): next fetch address, output byte, flags.
// Path: a normal instruction reads rx and then ry from the register-file RAM (one
// read port, registered read data), then goes through the bit-serial remainder
// unit that wraps the program counter modulo the effective program size, and
// finally loads the output register. The sequencer takes the next item only
// after handing its result to the output register. Once halted, an item needs
// no execution and goes straight to the output register.
// The output register frees the sequencer: a new item is accepted while the last
// result still waits; if the receiver stalls long enough the sequencer holds its
// finished item until the output register empties.
// Reset (rst_n low, asynchronous) clears the program counter, all flags and the
// register-file valid bits (registers read as zero until written), and sets
// prog_size to 256. Write prog_size through cfg_we/cfg_wdata only while idle.
module byte_vm_instruction_executor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bvm_pkg::in_item_t  in_item,
    output logic               res_valid,
    input  logic               res_ready,
    output bvm_pkg::res_item_t res_item,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_wdata
);
    import bvm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RX   = 3'd1;
    localparam logic [2:0] S_RY   = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam int CNT_W = $clog2(MOD_STEPS);

    // control state
    logic [2:0]          state_reg, state_next;
    logic [7:0]          pc_reg;
    logic                zero_flag_reg;
    logic                eof_flag_reg;
    logic                halt_flag_reg;
    logic [SIZE_W-1:0]   prog_size_reg;
    logic [NUM_REGS-1:0] reg_vld_reg;
    logic                res_valid_reg;
    logic                skip_reg;

    // datapath
    in_item_t            item_reg;
    res_item_t           pend_reg;
    res_item_t           res_item_reg;
    logic [WORD_W-1:0]   rx_val_reg;
    logic                vld_rd_reg;
    logic [SIZE_W-1:0]   dvd_reg;
    logic [SIZE_W-1:0]   div_reg;
    logic [SIZE_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                in_fire;
    logic                res_load;
    logic [SIZE_W-1:0]   size_eff;
    logic [REG_AW-1:0]   rx_idx;
    logic [REG_AW-1:0]   ry_idx;
    logic [REG_AW-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic                ram_we;
    logic [REG_AW-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_val;
    logic                wr_en;
    logic [WORD_W-1:0]   ry_val;
    logic                zero_next;
    logic                eof_next;
    logic                halt_next;
    logic                jump;
    logic [7:0]          advance;
    logic                ovalid;
    logic [WORD_W-1:0]   obyte;
    logic                took;
    logic [SIZE_W:0]     trial;
    logic [SIZE_W-1:0]   rem_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign res_load  = (state_reg == S_FIN) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // Effective program size: zero acts as one, anything above the maximum saturates.
    always_comb
    begin
        if (prog_size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (prog_size_reg > SIZE_W'(MAX_PROG))
        begin
            size_eff = SIZE_W'(MAX_PROG);
        end
        else
        begin
            size_eff = prog_size_reg;
        end
    end

    // Register indices wrap modulo the register count (low bits of each nibble).
    assign rx_idx    = item_reg.operand[0 +: REG_AW];
    assign ry_idx    = item_reg.operand[4 +: REG_AW];
    assign ram_raddr = (state_reg == S_IDLE) ? in_item.operand[0 +: REG_AW] : ry_idx;

    // Entries never written since reset read as zero.
    assign ry_val = ram_rdata & {WORD_W{vld_rd_reg}};

    // Execute: rx arrived last cycle, ry arrives now.
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = rx_idx;
        wr_val    = rx_val_reg;
        zero_next = zero_flag_reg;
        eof_next  = eof_flag_reg;
        halt_next = 1'b0;
        jump      = 1'b0;
        advance   = PC_STEP;
        ovalid    = 1'b0;
        obyte     = '0;
        took      = 1'b0;
        unique case (item_reg.op)
            OP_INC:
            begin
                wr_en  = 1'b1;
                wr_val = rx_val_reg + WORD_W'(1);
            end
            OP_DEC:
            begin
                wr_en  = 1'b1;
                wr_val = rx_val_reg - WORD_W'(1);
            end
            OP_MOV:
            begin
                wr_en  = 1'b1;
                wr_val = ry_val;
            end
            OP_LDI:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_val  = item_reg.operand;
            end
            OP_SHL:
            begin
                wr_en  = 1'b1;
                wr_val = {rx_val_reg[WORD_W-2:0], 1'b0};
            end
            OP_SHR:
            begin
                wr_en  = 1'b1;
                wr_val = {1'b0, rx_val_reg[WORD_W-1:1]};
            end
            OP_JMP:  jump = 1'b1;
            OP_JZ:   jump = zero_flag_reg;
            OP_JNZ:  jump = !zero_flag_reg;
            OP_JEOF: jump = eof_flag_reg;
            OP_HALT:
            begin
                halt_next = 1'b1;
                advance   = '0;
            end
            OP_ADD:
            begin
                wr_en  = 1'b1;
                wr_val = rx_val_reg + ry_val;
            end
            OP_SUB:
            begin
                wr_en  = 1'b1;
                wr_val = rx_val_reg - ry_val;
            end
            OP_XOR:
            begin
                wr_en  = 1'b1;
                wr_val = rx_val_reg ^ ry_val;
            end
            OP_OR:
            begin
                wr_en  = 1'b1;
                wr_val = rx_val_reg | ry_val;
            end
            OP_IN:
            begin
                wr_en = 1'b1;
                if (item_reg.in_eof)
                begin
                    wr_val   = EOF_BYTE;
                    eof_next = 1'b1;
                end
                else
                begin
                    wr_val   = item_reg.in_byte;
                    eof_next = 1'b0;
                    took     = 1'b1;
                end
            end
            OP_OUT:
            begin
                ovalid = 1'b1;
                obyte  = rx_val_reg;
            end
            default: ;
        endcase
        if (jump)
        begin
            advance = item_reg.operand;
        end
        // flag rules: arithmetic tests the result, move and output clear it
        unique case (item_reg.op)
            OP_INC, OP_DEC, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_XOR, OP_OR:
                zero_next = (wr_val == '0);
            OP_MOV, OP_OUT:
                zero_next = 1'b0;
            default: ;
        endcase
    end

    assign ram_we = (state_reg == S_RY) && wr_en;

    // One restoring step of (pc + advance) mod size; (pc + opd mod s) mod s folds into this.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[SIZE_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = SIZE_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = halt_flag_reg ? S_FIN : S_RX;
                end
            end
            S_RX:  state_next = S_RY;
            S_RY:  state_next = S_MOD;
            S_MOD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            zero_flag_reg <= 1'b0;
            eof_flag_reg  <= 1'b0;
            halt_flag_reg <= 1'b0;
            prog_size_reg <= SIZE_W'(MAX_PROG);
            reg_vld_reg   <= '0;
            res_valid_reg <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                prog_size_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                skip_reg <= halt_flag_reg;
            end
            if (state_reg == S_RY)
            begin
                zero_flag_reg <= zero_next;
                eof_flag_reg  <= eof_next;
                halt_flag_reg <= halt_flag_reg | halt_next;
            end
            if (ram_we)
            begin
                reg_vld_reg[wr_addr] <= 1'b1;
            end
            // advance the counter only for executed instructions
            if (res_load && !skip_reg)
            begin
                pc_reg <= rem_reg[7:0];
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        vld_rd_reg <= reg_vld_reg[ram_raddr];
        if (in_fire)
        begin
            item_reg <= in_item;
            // a halted machine reports its held state and does nothing else
            pend_reg.next_pc    <= pc_reg;
            pend_reg.out_valid  <= 1'b0;
            pend_reg.out_byte   <= '0;
            pend_reg.took_input <= 1'b0;
            pend_reg.zero       <= zero_flag_reg;
            pend_reg.halted     <= 1'b1;
        end
        if (state_reg == S_RX)
        begin
            rx_val_reg <= ry_val;
        end
        if (state_reg == S_RY)
        begin
            pend_reg.next_pc    <= pc_reg;
            pend_reg.out_valid  <= ovalid;
            pend_reg.out_byte   <= obyte;
            pend_reg.took_input <= took;
            pend_reg.zero       <= zero_next;
            pend_reg.halted     <= halt_next;
            dvd_reg <= {1'b0, pc_reg} + {1'b0, advance};
            div_reg <= size_eff;
            rem_reg <= '0;
            cnt_reg <= CNT_W'(MOD_STEPS - 1);
        end
        if (state_reg == S_MOD)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[SIZE_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (res_load)
        begin
            res_item_reg.next_pc    <= skip_reg ? pc_reg : rem_reg[7:0];
            res_item_reg.out_valid  <= pend_reg.out_valid;
            res_item_reg.out_byte   <= pend_reg.out_byte;
            res_item_reg.took_input <= pend_reg.took_input;
            res_item_reg.zero       <= pend_reg.zero;
            res_item_reg.halted     <= pend_reg.halted;
        end
    end

    bvm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (wr_val),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_flag_reg |=> halt_flag_reg)
        else $error("halt flag dropped");

    // The remainder never reaches the divisor during the wrap step.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (rem_reg < div_reg))
        else $error("remainder out of range");

    // A register write marks its entry as holding data.
    a_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> reg_vld_reg[$past(wr_addr)])
        else $error("valid bit not set after write");

    // An output byte is zero unless emitted, and never with an input take.
    a_res_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((res_item_reg.out_valid || (res_item_reg.out_byte == '0))
                           && !(res_item_reg.out_valid && res_item_reg.took_input)))
        else $error("inconsistent result fields");

endmodule

// ===== bench/byte_vm_instruction_executor_test.sv =====
// Self-checking bench for the byte VM executor: shadow machine, randomised items and stalls.
`timescale 1ns / 1ps

module byte_vm_instruction_executor_test;
    import bvm_pkg::*;

    // Shadow copy of the machine: executes every accepted item and holds the results
    // that the block still owes, oldest first.
    class vm_shadow;
        logic [7:0] regs [NUM_REGS];
        logic [7:0] pc;
        logic [8:0] size_reg;
        bit         zf;
        bit         eof_seen;
        bit         halted;
        res_item_t  due_results [$];
        int         mismatches;

        function void power_up();
            foreach (regs[i])
                regs[i] = 8'd0;
            pc         = 8'd0;
            size_reg   = 9'd256;
            zf         = 1'b0;
            eof_seen   = 1'b0;
            halted     = 1'b0;
            mismatches = 0;
            due_results.delete();
        endfunction

        function void set_size(logic [8:0] v);
            size_reg = v;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        // Run one instruction and queue the result it must produce.
        function void execute(in_item_t it);
            res_item_t   r;
            int unsigned sz;
            int unsigned adv;
            logic [3:0]  rx;
            logic [3:0]  ry;
            bit          jmp;
            bit          upd;

            r   = '0;
            rx  = it.operand[3:0];
            ry  = it.operand[7:4];
            adv = 32'(PC_STEP);
            jmp = 1'b0;
            upd = 1'b0;
            // Clamp the size: zero behaves as one, anything past the program store as its end.
            sz = 32'(size_reg);
            if (sz == 0)
                sz = 1;
            if (sz > MAX_PROG)
                sz = MAX_PROG;

            // Once halted, echo the held state and change nothing.
            if (halted)
            begin
                r.next_pc = pc;
                r.zero    = zf;
                r.halted  = 1'b1;
                due_results.push_back(r);
                return;
            end

            case (it.op)
                OP_INC:  begin regs[rx] = regs[rx] + 8'd1;     upd = 1'b1; end
                OP_DEC:  begin regs[rx] = regs[rx] - 8'd1;     upd = 1'b1; end
                OP_MOV:  begin zf = 1'b0; regs[rx] = regs[ry]; end
                OP_LDI:  regs[0] = it.operand;
                OP_SHL:  begin regs[rx] = regs[rx] << 1;       upd = 1'b1; end
                OP_SHR:  begin regs[rx] = regs[rx] >> 1;       upd = 1'b1; end
                OP_JMP:  jmp = 1'b1;
                OP_JZ:   jmp = zf;
                OP_JNZ:  jmp = !zf;
                OP_JEOF: jmp = eof_seen;
                OP_HALT: begin halted = 1'b1; adv = 0; end
                OP_ADD:  begin regs[rx] = regs[rx] + regs[ry]; upd = 1'b1; end
                OP_SUB:  begin regs[rx] = regs[rx] - regs[ry]; upd = 1'b1; end
                OP_XOR:  begin regs[rx] = regs[rx] ^ regs[ry]; upd = 1'b1; end
                OP_OR:   begin regs[rx] = regs[rx] | regs[ry]; upd = 1'b1; end
                OP_IN:
                begin
                    // At end of input the register takes all ones and nothing is consumed.
                    if (it.in_eof)
                    begin
                        regs[rx] = EOF_BYTE;
                        eof_seen = 1'b1;
                    end
                    else
                    begin
                        regs[rx]     = it.in_byte;
                        eof_seen     = 1'b0;
                        r.took_input = 1'b1;
                    end
                end
                OP_OUT:
                begin
                    zf          = 1'b0;
                    r.out_valid = 1'b1;
                    r.out_byte  = regs[rx];
                end
                default: ;
            endcase

            if (upd)
                zf = (regs[rx] == 8'd0);
            if (jmp)
                adv = it.operand % sz;
            pc = 8'((pc + adv) % sz);

            r.next_pc = pc;
            r.zero    = zf;
            r.halted  = halted;
            due_results.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] seen);
            if (want !== seen)
            begin
                mismatches++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
            end
        endfunction

        // Compare one accepted result against the oldest owed one.
        function void compare(res_item_t got);
            res_item_t want;

            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing owed, expected none, got %h",
                         $time, got);
                return;
            end
            want = due_results.pop_front();
            check_field("next_pc",    want.next_pc,        got.next_pc);
            check_field("out_valid",  8'(want.out_valid),  8'(got.out_valid));
            check_field("out_byte",   want.out_byte,       got.out_byte);
            check_field("took_input", 8'(want.took_input), 8'(got.took_input));
            check_field("zero",       8'(want.zero),       8'(got.zero));
            check_field("halted",     8'(want.halted),     8'(got.halted));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_item;
    logic       res_valid;
    logic       res_ready;
    res_item_t  res_item;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    vm_shadow board;
    bit       calm;          // no idling on either side while set
    int       hold_off;      // cycles for the receiver to stall, handed over by the sender

    byte_vm_instruction_executor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Check every result that crosses the output handshake.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            board.compare(res_item);
    end

    // Receiver: short random stalls, a few long ones, and the long hold-off on request.
    initial
    begin
        int n;
        int r;
        int stall_left;

        stall_left = 0;
        res_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                // Hold the output shut so the block fills up and stalls its input.
                n        = hold_off;
                hold_off = 0;
                res_ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            if (calm)
                res_ready = 1'b1;
            else if (stall_left > 0)
            begin
                res_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_ready = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 23)
                    stall_left = $urandom_range(15, 60);
            end
        end
    end

    function automatic in_item_t make_item(logic [7:0] op, logic [7:0] operand,
                                           logic [7:0] in_byte, logic in_eof);
        in_item_t it;

        it.op      = op;
        it.operand = operand;
        it.in_byte = in_byte;
        it.in_eof  = in_eof;
        return it;
    endfunction

    // Mostly real opcodes with random operands; the rest any byte. Never halt here.
    function automatic in_item_t random_item();
        in_item_t it;

        it.operand = 8'($urandom);
        it.in_byte = 8'($urandom);
        it.in_eof  = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 85)
            it.op = 8'($urandom_range(1, 17));
        else
            it.op = 8'($urandom_range(0, 255));
        while (it.op == OP_HALT)
            it.op = 8'($urandom_range(0, 255));
        // Now and then subtract or xor a register from itself to raise the zero flag.
        if ((it.op == OP_SUB || it.op == OP_XOR) && $urandom_range(0, 2) == 0)
            it.operand[7:4] = it.operand[3:0];
        return it;
    endfunction

    function automatic int sender_gap();
        int r;

        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present an item at the falling edge and hold it until the block takes it.
    task automatic offer_item(in_item_t it);
        @(negedge clk);
        in_item  = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.execute(it);
    endtask

    task automatic idle_sender(int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every owed result has arrived.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic write_prog_size(logic [8:0] v);
        drain();
        // Let the pipeline settle before touching the register.
        repeat (16) @(negedge clk);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        board.set_size(v);
    endtask

    initial
    begin
        in_item_t   directed [$];
        logic [8:0] sizes [9];

        board = new;
        board.power_up();
        calm      = 1'b0;
        hold_off  = 0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 9'd0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every opcode but halt, taken and untaken jumps, end of input, odd opcodes.
        directed.push_back(make_item(OP_LDI,  8'hFF, 8'h00, 1'b0));
        directed.push_back(make_item(OP_INC,  8'h00, 8'h00, 1'b0)); // wraps to zero
        directed.push_back(make_item(OP_JZ,   8'h10, 8'h00, 1'b0)); // taken
        directed.push_back(make_item(OP_DEC,  8'h00, 8'h00, 1'b0)); // wraps to all ones
        directed.push_back(make_item(OP_JNZ,  8'hFE, 8'h00, 1'b0)); // taken
        directed.push_back(make_item(OP_JZ,   8'h20, 8'h00, 1'b0)); // not taken
        directed.push_back(make_item(OP_MOV,  8'h01, 8'h00, 1'b0));
        directed.push_back(make_item(OP_SHL,  8'h01, 8'h00, 1'b0));
        directed.push_back(make_item(OP_SHR,  8'h01, 8'h00, 1'b0));
        directed.push_back(make_item(OP_ADD,  8'h01, 8'h00, 1'b0));
        directed.push_back(make_item(OP_SUB,  8'h12, 8'h00, 1'b0));
        directed.push_back(make_item(OP_XOR,  8'h22, 8'h00, 1'b0)); // self xor gives zero
        directed.push_back(make_item(OP_OR,   8'h13, 8'h00, 1'b0));
        directed.push_back(make_item(OP_IN,   8'h0F, 8'hA5, 1'b0));
        directed.push_back(make_item(OP_JEOF, 8'h40, 8'h00, 1'b0)); // not taken
        directed.push_back(make_item(OP_IN,   8'h04, 8'h5A, 1'b1)); // end of input
        directed.push_back(make_item(OP_JEOF, 8'hFF, 8'h00, 1'b0)); // taken
        directed.push_back(make_item(OP_OUT,  8'hFF, 8'h00, 1'b0));
        directed.push_back(make_item(OP_IN,   8'h05, 8'hFF, 1'b0)); // clears end flag
        directed.push_back(make_item(OP_OUT,  8'h00, 8'hFF, 1'b1));
        directed.push_back(make_item(OP_JMP,  8'h00, 8'h00, 1'b0)); // jump by nothing
        directed.push_back(make_item(8'h00,   8'hFF, 8'hFF, 1'b1)); // no-op opcodes
        directed.push_back(make_item(8'hFF,   8'h00, 8'h00, 1'b0));
        directed.push_back(make_item(8'h12,   8'h55, 8'hAA, 1'b0));
        foreach (directed[i])
        begin
            offer_item(directed[i]);
            idle_sender(sender_gap());
        end

        // Random phases across sizes: clamped zero, one, past the store, small, and full.
        // The shrink from full size can leave the counter beyond the new size.
        sizes = '{9'd37, 9'd0, 9'd1, 9'd511, 9'd2, 9'd257, 9'd256, 9'd100, 9'd3};
        foreach (sizes[p])
        begin
            write_prog_size(sizes[p]);
            calm = (p == 4);
            for (int i = 0; i < 50; i++)
            begin
                if (p == 2 && i == 10)
                    hold_off = 300;
                if (p == 6 && i == 25)
                    drain();
                offer_item(random_item());
                idle_sender(sender_gap());
            end
            calm = 1'b0;
        end

        // Halt last: nothing after it moves the machine again.
        offer_item(make_item(OP_HALT, 8'h33, 8'h00, 1'b0));
        idle_sender(sender_gap());
        offer_item(make_item(OP_OUT, 8'h00, 8'h00, 1'b0));
        offer_item(make_item(OP_IN,  8'h01, 8'h7E, 1'b0));
        offer_item(make_item(OP_JMP, 8'h05, 8'h00, 1'b0));
        for (int i = 0; i < 5; i++)
        begin
            offer_item(random_item());
            idle_sender(sender_gap());
        end

        drain();
        repeat (30) @(posedge clk);
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
